/* rtl/spf_pkg.sv */
// ----------------------------------------------------------------------------
// spf_pkg : shared types and constants of the sieve factoriser
// Word widths, controller states and the command/status groups that join
// the controller to the datapath.
// ----------------------------------------------------------------------------
package spf_pkg;

   localparam int NUM_W    = 17;  // query number width
   localparam int FACTOR_W = 16;  // table entry and result factor width
   localparam int DIV_BITS = 4;   // quotient bits resolved per divider cycle

   typedef enum logic [3:0] {
      S_CLEAR,
      S_CHECK_I,
      S_READ_I,
      S_TEST_I,
      S_READ_J,
      S_MARK_J,
      S_IDLE,
      S_FACT_READ,
      S_FACT_TEST,
      S_FACT_DIV
   } spf_state_type;

   // controller to datapath
   typedef struct packed {
      logic clr_wr;        // write zero at the clearing counter, advance it
      logic i_init;        // start the sieve at two
      logic i_next;        // advance the sieve prime candidate
      logic rd_i;          // read the entry of the candidate
      logic j_init;        // start the multiples at the candidate squared
      logic rd_j;          // read the entry of the current multiple
      logic j_next;        // advance the multiple
      logic mark_wr;       // mark the current multiple with the candidate
      logic load_rem;      // load the remainder from the query word
      logic rd_rem;        // read the entry of the remainder
      logic emit;          // load the result register
      logic div_start;     // divide the remainder by its entry
      logic rem_from_div;  // take the quotient as the new remainder
   } spf_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic cnt_done;      // clearing counter is at the last entry
      logic sq_over;       // candidate squared is past the table end
      logic j_last;        // next multiple is past the table end
      logic entry_zero;    // read entry is unmarked (index is prime)
      logic num_ok;        // query number lies in two to table size
      logic out_free;      // result register can take a word
      logic div_done;      // quotient ready
   } spf_status_type;

endpackage

/* rtl/spf_stream_if.sv */
// ----------------------------------------------------------------------------
// spf_req_if / spf_rsp_if : valid/ready channels of the sieve factoriser
// Query channel carries the number, result channel one prime factor.
// ----------------------------------------------------------------------------
interface spf_req_if;
   logic                       valid;
   logic                       ready;
   logic [spf_pkg::NUM_W-1:0]  number;

   modport source (output valid, output number, input ready);
   modport sink   (input valid, input number, output ready);
endinterface

interface spf_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [spf_pkg::FACTOR_W-1:0]  prime_factor;
   logic                          last;

   modport source (output valid, output prime_factor, output last, input ready);
   modport sink   (input valid, input prime_factor, input last, output ready);
endinterface

/* rtl/spf_divider.sv */
// ----------------------------------------------------------------------------
// spf_divider : multi-cycle restoring divider
// Resolves DIV_BITS quotient bits per cycle, MSB first; pulses done once.
// ----------------------------------------------------------------------------
module spf_divider #(
   parameter int DVD_W = 17
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [DVD_W-1:0]              dividend,
   input  logic [spf_pkg::FACTOR_W-1:0]  divisor,
   output logic                          done,
   output logic [DVD_W-1:0]              quotient
);

   localparam int STEPS = (DVD_W + spf_pkg::DIV_BITS - 1) / spf_pkg::DIV_BITS;
   localparam int PAD_W = STEPS * spf_pkg::DIV_BITS;
   localparam int CNT_W = $clog2(STEPS + 1);
   localparam int PR_W  = spf_pkg::FACTOR_W + 1;

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [CNT_W-1:0]              cnt_ff, cnt_in;
   logic [PAD_W-1:0]              dvd_ff, dvd_in;
   logic [PR_W-1:0]               pr_ff, pr_in;
   logic [spf_pkg::FACTOR_W-1:0]  dsr_ff, dsr_in;
   logic [PAD_W-1:0]              dvd_step;
   logic [PR_W-1:0]               pr_step;

   // one cycle's worth of shift-and-subtract; quotient bits enter at the LSB
   always_comb begin
      dvd_step = dvd_ff;
      pr_step  = pr_ff;
      for (int k = 0; k < spf_pkg::DIV_BITS; k++) begin
         pr_step  = {pr_step[PR_W-2:0], dvd_step[PAD_W-1]};
         dvd_step = {dvd_step[PAD_W-2:0], 1'b0};
         if (pr_step >= {1'b0, dsr_ff}) begin
            pr_step     = pr_step - {1'b0, dsr_ff};
            dvd_step[0] = 1'b1;
         end
      end
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      pr_in   = pr_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = PAD_W'(dividend);
         pr_in   = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         dvd_in = dvd_step;
         pr_in  = pr_step;
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      pr_ff  <= pr_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = dvd_ff[DVD_W-1:0];

   a_div_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider restarted while busy");

   a_div_latency: assert property (@(posedge clock) disable iff (reset)
      start |-> ##(STEPS + 1) done_ff)
      else $error("divider quotient late");

endmodule

/* rtl/spf_controller.sv */
// ----------------------------------------------------------------------------
// spf_controller : sequencer of the sieve factoriser
// Clears the table, runs the sieve, then factorises one query at a time.
// ----------------------------------------------------------------------------
module spf_controller (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  spf_pkg::spf_status_type  status,
   output spf_pkg::spf_cmd_type     cmd
);

   spf_pkg::spf_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= spf_pkg::S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         spf_pkg::S_CLEAR: begin
            cmd.clr_wr = 1'b1;
            if (status.cnt_done) begin
               cmd.i_init = 1'b1;
               state_in   = spf_pkg::S_CHECK_I;
            end
         end
         spf_pkg::S_CHECK_I: begin
            state_in = status.sq_over ? spf_pkg::S_IDLE : spf_pkg::S_READ_I;
         end
         spf_pkg::S_READ_I: begin
            cmd.rd_i = 1'b1;
            state_in = spf_pkg::S_TEST_I;
         end
         spf_pkg::S_TEST_I: begin
            if (status.entry_zero) begin
               cmd.j_init = 1'b1;
               state_in   = spf_pkg::S_READ_J;
            end else begin
               cmd.i_next = 1'b1;
               state_in   = spf_pkg::S_CHECK_I;
            end
         end
         spf_pkg::S_READ_J: begin
            cmd.rd_j = 1'b1;
            state_in = spf_pkg::S_MARK_J;
         end
         spf_pkg::S_MARK_J: begin
            cmd.mark_wr = status.entry_zero;
            cmd.j_next  = 1'b1;
            if (status.j_last) begin
               cmd.i_next = 1'b1;
               state_in   = spf_pkg::S_CHECK_I;
            end else begin
               state_in = spf_pkg::S_READ_J;
            end
         end
         spf_pkg::S_IDLE: begin
            // out-of-range numbers are taken and dropped
            req_ready = 1'b1;
            if (req_valid && status.num_ok) begin
               cmd.load_rem = 1'b1;
               state_in     = spf_pkg::S_FACT_READ;
            end
         end
         spf_pkg::S_FACT_READ: begin
            cmd.rd_rem = 1'b1;
            state_in   = spf_pkg::S_FACT_TEST;
         end
         spf_pkg::S_FACT_TEST: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               if (status.entry_zero) begin
                  state_in = spf_pkg::S_IDLE;
               end else begin
                  cmd.div_start = 1'b1;
                  state_in      = spf_pkg::S_FACT_DIV;
               end
            end
         end
         spf_pkg::S_FACT_DIV: begin
            if (status.div_done) begin
               cmd.rem_from_div = 1'b1;
               state_in         = spf_pkg::S_FACT_READ;
            end
         end
         default: begin
            state_in = spf_pkg::S_CLEAR;
         end
      endcase
   end

endmodule

/* rtl/spf_datapath.sv */
// ----------------------------------------------------------------------------
// spf_datapath : factor table, sieve counters, remainder and result register
// Table entry zero marks an index that is its own smallest prime factor.
// ----------------------------------------------------------------------------
module spf_datapath #(
   parameter int TABLE_SIZE = 65536
) (
   input  logic                          clock,
   input  logic                          reset,
   input  spf_pkg::spf_cmd_type          cmd,
   output spf_pkg::spf_status_type       status,
   input  logic [spf_pkg::NUM_W-1:0]     req_number,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output logic [spf_pkg::FACTOR_W-1:0]  rsp_prime_factor,
   output logic                          rsp_last
);

   localparam int AW = $clog2(TABLE_SIZE + 1);
   localparam int CW = (AW > spf_pkg::NUM_W) ? AW : spf_pkg::NUM_W;
   localparam logic [AW-1:0] TS_A = AW'(TABLE_SIZE);
   localparam logic [AW:0]   TS_X = (AW + 1)'(TABLE_SIZE);
   localparam logic [CW-1:0] TS_C = CW'(TABLE_SIZE);

   logic [spf_pkg::FACTOR_W-1:0]  factor_mem [0:TABLE_SIZE];

   logic [AW-1:0]                 clr_cnt_ff, clr_cnt_in;
   logic [AW-1:0]                 i_ff, i_in;
   logic [AW:0]                   sq_ff, sq_in;
   logic [AW:0]                   j_ff, j_in;
   logic [AW-1:0]                 rem_ff, rem_in;
   logic [spf_pkg::FACTOR_W-1:0]  rdata_ff;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [spf_pkg::FACTOR_W-1:0]  rsp_factor_ff, rsp_factor_in;
   logic                          rsp_last_ff, rsp_last_in;

   logic [AW:0]                   j_plus;
   logic [CW-1:0]                 number_ext;
   logic                          rd_en, wr_en;
   logic [AW-1:0]                 rd_addr, wr_addr;
   logic [spf_pkg::FACTOR_W-1:0]  wr_data;
   logic                          div_done;
   logic [AW-1:0]                 div_quot;
   logic                          entry_zero;

   assign entry_zero = (rdata_ff == '0);
   assign j_plus     = j_ff + (AW + 1)'(i_ff);
   assign number_ext = CW'(req_number);

   always_comb begin
      status.cnt_done   = (clr_cnt_ff == TS_A);
      status.sq_over    = (sq_ff > TS_X);
      status.j_last     = (j_plus > TS_X);
      status.entry_zero = entry_zero;
      status.num_ok     = (number_ext >= CW'(2)) && (number_ext <= TS_C);
      status.out_free   = !rsp_valid_ff || rsp_ready;
      status.div_done   = div_done;
   end

   // table port selection
   always_comb begin
      rd_en   = cmd.rd_i || cmd.rd_j || cmd.rd_rem;
      rd_addr = cmd.rd_i ? i_ff : (cmd.rd_j ? j_ff[AW-1:0] : rem_ff);
      wr_en   = cmd.clr_wr || cmd.mark_wr;
      wr_addr = cmd.clr_wr ? clr_cnt_ff : j_ff[AW-1:0];
      wr_data = cmd.clr_wr ? '0 : spf_pkg::FACTOR_W'(i_ff);
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         factor_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= factor_mem[rd_addr];
      end
   end

   always_comb begin
      clr_cnt_in = cmd.clr_wr ? clr_cnt_ff + AW'(1) : clr_cnt_ff;

      // (i+1)^2 = i^2 + 2i + 1
      i_in  = i_ff;
      sq_in = sq_ff;
      if (cmd.i_init) begin
         i_in  = AW'(2);
         sq_in = (AW + 1)'(4);
      end else if (cmd.i_next) begin
         i_in  = i_ff + AW'(1);
         sq_in = sq_ff + {i_ff, 1'b1};
      end

      j_in = j_ff;
      if (cmd.j_init) begin
         j_in = sq_ff;
      end else if (cmd.j_next) begin
         j_in = j_plus;
      end

      rem_in = rem_ff;
      if (cmd.load_rem) begin
         rem_in = AW'(req_number);
      end else if (cmd.rem_from_div) begin
         rem_in = div_quot;
      end

      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_factor_in = rsp_factor_ff;
      rsp_last_in   = rsp_last_ff;
      if (cmd.emit) begin
         rsp_valid_in  = 1'b1;
         rsp_factor_in = entry_zero ? spf_pkg::FACTOR_W'(rem_ff) : rdata_ff;
         rsp_last_in   = entry_zero;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff          <= i_in;
      sq_ff         <= sq_in;
      j_ff          <= j_in;
      rem_ff        <= rem_in;
      rsp_factor_ff <= rsp_factor_in;
      rsp_last_ff   <= rsp_last_in;
   end

   spf_divider #(
      .DVD_W (AW)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (rem_ff),
      .divisor  (rdata_ff),
      .done     (div_done),
      .quotient (div_quot)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_prime_factor = rsp_factor_ff;
   assign rsp_last         = rsp_last_ff;

   a_dp_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> status.out_free)
      else $error("result word overwritten before it was taken");

   a_dp_factor_prime: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && !entry_zero) |-> (rdata_ff >= spf_pkg::FACTOR_W'(2)))
      else $error("marked table entry below two");

   a_dp_rem_shrinks: assert property (@(posedge clock) disable iff (reset)
      cmd.rem_from_div |-> (div_quot < rem_ff))
      else $error("remainder did not shrink after division");

endmodule

/* rtl/spf_sieve_factorizer_top.sv */
// ----------------------------------------------------------------------------
// spf_sieve_factorizer_top : smallest-prime-factor sieve and factoriser
// Builds a smallest-prime-factor table after reset, then streams the prime
// factors of each query number in ascending order with multiplicity.
// ----------------------------------------------------------------------------
//
//   channel    | direction | word fields                 | handshake
//   -----------+-----------+-----------------------------+--------------
//   req_chan   | in        | number[16:0]                | valid/ready
//   rsp_chan   | out       | prime_factor[15:0], last    | valid/ready
//
// Reset (synchronous) clears all TABLE_SIZE+1 table entries, one entry a
// cycle, then sieves the table: each candidate up to sqrt(TABLE_SIZE) is
// checked, read and tested, and each multiple of each prime from its square
// is read and then marked if it is still unmarked.
// req_chan.ready stays low until the table is built.
// For each non-final factor a query takes one table read plus a division by
// the 4-bit-per-cycle divider; the final factor takes the table read alone.
// Numbers 0, 1 and above TABLE_SIZE are taken and produce no words.
// A stalled result word holds in the output register; the block stops
// before its next emission until the word is taken.
// ----------------------------------------------------------------------------
module spf_sieve_factorizer_top #(
   parameter int TABLE_SIZE = 65536
) (
   input  logic        clock,
   input  logic        reset,
   spf_req_if.sink     req_chan,
   spf_rsp_if.source   rsp_chan
);

   // commands from the sequencer, status back from the datapath
   spf_pkg::spf_cmd_type     cmd;
   spf_pkg::spf_status_type  status;

   // sequencer: clear, sieve, then one query at a time
   spf_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // table memory, sieve counters, remainder, divider and result register
   spf_datapath #(
      .TABLE_SIZE (TABLE_SIZE)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_number       (req_chan.number),
      .rsp_ready        (rsp_chan.ready),
      .rsp_valid        (rsp_chan.valid),
      .rsp_prime_factor (rsp_chan.prime_factor),
      .rsp_last         (rsp_chan.last)
   );

endmodule
